@@ design/clcg_shuf_pkg.sv @@
// package for the combined lcg shuffle generator
// holds payload types, state codes, generator constants; no dependencies
package clcg_shuf_pkg;

    // default shuffle table depth
    localparam int TABLE_DEPTH_DEF = 32;

    // generator constants, moduli written as 2^31 - c
    localparam logic [15:0] MUL_ONE   = 16'd40014;
    localparam logic [15:0] MUL_TWO   = 16'd40692;
    localparam logic [7:0]  MOD_ONE_C = 8'd85;
    localparam logic [7:0]  MOD_TWO_C = 8'd249;

    // value limits and reset values
    localparam logic [30:0] TOP_VALUE = 31'd2147483562;
    localparam logic [30:0] OUT_MAX   = 31'd2147483305;
    localparam logic [30:0] X_RESET   = 31'd1;
    localparam logic [30:0] Y_RESET   = 31'd123456789;

    // slot divider constants
    localparam longint unsigned TOP_NUM = 64'd2147483562;
    localparam int RECIP_SHIFT = 38;

    // command codes
    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    // input and output payloads
    typedef struct packed {
        logic        command;
        logic [30:0] seed_value;
    } t_cmd_item;

    typedef struct packed {
        logic [30:0] deviate;
    } t_dev_item;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_RED,
        ST_MUL,
        ST_RED,
        ST_FIX,
        ST_MIX
    } t_state;

endpackage

@@ design/clcg_shuf_stream_if.sv @@
// valid/ready stream interface with a typed payload
// no dependencies; payload type set where it is instantiated
interface clcg_shuf_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/clcg_shuf_modmul.sv @@
// constant multiplier with modular fold for moduli of the form 2^31 - c
// product registered, fold and single correction after it; uses clcg_shuf_pkg
module clcg_shuf_modmul #(
    parameter logic [15:0] MULT  = clcg_shuf_pkg::MUL_ONE,
    parameter logic [7:0]  MOD_C = clcg_shuf_pkg::MOD_ONE_C
) (
    input  logic        i_clk,
    input  logic [30:0] i_operand,
    output logic [30:0] o_result
);
    import clcg_shuf_pkg::*;

    localparam logic [31:0] MODULUS = 32'h8000_0000 - 32'(MOD_C);

    logic [46:0] r_prod;
    logic [23:0] w_hi_fold;
    logic [31:0] w_fold;

    // product register, reloaded every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= 47'(i_operand) * 47'(MULT);
    end

    // 2^31 is congruent to c, sum stays below twice the modulus
    assign w_hi_fold = 24'(r_prod[46:31]) * 24'(MOD_C);
    assign w_fold    = 32'(r_prod[30:0]) + 32'(w_hi_fold);
    assign o_result  = (w_fold >= MODULUS) ? 31'(w_fold - MODULUS) : w_fold[30:0];

endmodule

@@ design/clcg_shuf_slot.sv @@
// table slot from the previous output: divide by a constant via reciprocal
// two register stages then one compare; uses clcg_shuf_pkg
module clcg_shuf_slot #(
    parameter int TABLE_DEPTH = clcg_shuf_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic [30:0]                    i_last,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_slot
);
    import clcg_shuf_pkg::*;

    localparam int A_W  = $clog2(TABLE_DEPTH);
    localparam int Q_W  = $clog2(TABLE_DEPTH + 1);
    localparam int PQ_W = RECIP_SHIFT + Q_W;
    localparam longint unsigned SLOT_DIV = 1 + TOP_NUM / TABLE_DEPTH;
    localparam longint unsigned RECIP    = (64'd1 << RECIP_SHIFT) / SLOT_DIV;
    localparam logic [31:0] SLOT_DIV_32  = 32'(SLOT_DIV);

    logic [PQ_W-1:0] r_pq;
    logic [Q_W-1:0]  r_q;
    logic [31:0]     r_qd;
    logic [Q_W-1:0]  w_q_est;
    logic [32:0]     w_bound;
    logic            w_bump;
    logic [Q_W:0]    w_q_fix;

    // estimate is the true quotient or one below it
    assign w_q_est = r_pq[RECIP_SHIFT +: Q_W];

    always_ff @(posedge i_clk) begin
        r_pq <= PQ_W'(i_last) * PQ_W'(RECIP);
        r_q  <= w_q_est;
        r_qd <= 32'(w_q_est) * SLOT_DIV_32;
    end

    // correct by one, then limit to the last entry
    assign w_bound = 33'(r_qd) + 33'(SLOT_DIV_32);
    assign w_bump  = (33'(i_last) >= w_bound);
    assign w_q_fix = (Q_W+1)'(r_q) + (Q_W+1)'(w_bump);
    assign o_slot  = (w_q_fix > (Q_W+1)'(TABLE_DEPTH - 1)) ? A_W'(TABLE_DEPTH - 1)
                                                            : w_q_fix[A_W-1:0];

endmodule

@@ design/clcg_shuf_table.sv @@
// shuffle table memory, one write and one registered read port
// per-entry valid bits make unwritten entries read as zero; uses clcg_shuf_pkg
module clcg_shuf_table #(
    parameter int TABLE_DEPTH = clcg_shuf_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_rd_addr,
    output logic [30:0]                    o_rd_data,
    input  logic                           i_wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_wr_addr,
    input  logic [30:0]                    i_wr_data
);
    import clcg_shuf_pkg::*;

    logic [30:0]            mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [30:0]            r_rd_data;
    logic                   r_rd_valid;

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

@@ design/combined_lcg_shuffle_random.sv @@
// Combined two-generator LCG with a shuffle table; one deviate per command.
// Channels: i_cmd takes a transaction {command, seed_value}; o_dev returns one
// transaction {deviate} per command, the numerator over 2147483563 in
// 1..2147483305.
// A draw command passes through accept, modular fold of both generators
// (with the slot quotient in parallel), table read, mix and table write back.
// The next command is accepted in the cycle after the result is registered.
// A reseed command adds a warm-up run of generator one, TABLE_DEPTH + 8 steps
// of a multiply state and a fold state each, plus one state to restart the
// multipliers, ahead of its draw.
// Reset restores generator one to 1, generator two to 123456789, the last
// output to 0 and marks every table entry as zero; the reset is synchronous.
// The result sits in an output register; while the receiver stalls, the
// block still accepts and works on the next command and holds before its
// table write until the output register is free.
// Depends on clcg_shuf_pkg, clcg_shuf_stream_if and the submodules.
module combined_lcg_shuffle_random #(
    parameter int TABLE_DEPTH = clcg_shuf_pkg::TABLE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    clcg_shuf_stream_if.sink          i_cmd,
    clcg_shuf_stream_if.source        o_dev
);
    import clcg_shuf_pkg::*;

    localparam int A_W = $clog2(TABLE_DEPTH);
    localparam int K_W = $clog2(TABLE_DEPTH + 8);
    localparam logic [K_W-1:0] K_INIT = K_W'(TABLE_DEPTH + 7);
    localparam logic [K_W-1:0] K_TAB  = K_W'(TABLE_DEPTH);

    t_state         r_state, n_state;
    logic [30:0]    r_x, n_x;
    logic [30:0]    r_y, n_y;
    logic [30:0]    r_last, n_last;
    logic [K_W-1:0] r_k, n_k;
    logic [A_W-1:0] r_slot, n_slot;
    logic           r_out_valid, n_out_valid;
    logic [30:0]    r_out_data, n_out_data;

    logic [30:0]    w_x_red;
    logic [30:0]    w_y_red;
    logic [A_W-1:0] w_slot;
    logic [30:0]    w_tab;
    logic [30:0]    w_seed;
    logic [30:0]    w_mix;
    logic           w_accept;
    logic           w_proceed;
    logic           w_rd_en;
    logic           w_wr_en;
    logic [A_W-1:0] w_wr_addr;
    logic [30:0]    w_wr_data;

    // generator one and two steppers
    clcg_shuf_modmul #(.MULT(MUL_ONE), .MOD_C(MOD_ONE_C)) u_gen_one (
        .i_clk     (i_clk),
        .i_operand (r_x),
        .o_result  (w_x_red)
    );

    clcg_shuf_modmul #(.MULT(MUL_TWO), .MOD_C(MOD_TWO_C)) u_gen_two (
        .i_clk     (i_clk),
        .i_operand (r_y),
        .o_result  (w_y_red)
    );

    // slot index from the previous output
    clcg_shuf_slot #(.TABLE_DEPTH(TABLE_DEPTH)) u_slot (
        .i_clk  (i_clk),
        .i_last (r_last),
        .o_slot (w_slot)
    );

    // shuffle table
    clcg_shuf_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_slot),
        .o_rd_data (w_tab),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // handshakes
    assign i_cmd.ready        = (r_state == ST_IDLE);
    assign w_accept           = i_cmd.valid && i_cmd.ready;
    assign w_proceed          = !r_out_valid || o_dev.ready;
    assign o_dev.valid        = r_out_valid;
    assign o_dev.data.deviate = r_out_data;

    // seed with zero taken as one
    assign w_seed = (i_cmd.data.seed_value == '0) ? 31'd1 : i_cmd.data.seed_value;

    // table entry minus generator two, wrapped into 1..TOP_VALUE
    assign w_mix = (w_tab <= r_y) ? 31'(32'(w_tab) + 32'(TOP_VALUE) - 32'(r_y))
                                  : 31'(w_tab - r_y);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_x         <= X_RESET;
            r_y         <= Y_RESET;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_x         <= n_x;
            r_y         <= n_y;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers without reset
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_slot     <= n_slot;
        r_out_data <= n_out_data;
    end

    // sequencer next state and control
    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_last      = r_last;
        n_k         = r_k;
        n_slot      = r_slot;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_rd_en     = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_slot;
        w_wr_data   = r_x;

        if (r_out_valid && o_dev.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_cmd.data.command == CMD_RESEED) begin
                        n_x     = w_seed;
                        n_y     = w_seed;
                        n_k     = K_INIT;
                        n_state = ST_SEED_MUL;
                    end else begin
                        n_state = ST_RED;
                    end
                end
            end
            ST_SEED_MUL: begin
                n_state = ST_SEED_RED;
            end
            ST_SEED_RED: begin
                // warm-up step, the last entries of the run fill the table
                n_x = w_x_red;
                if (r_k < K_TAB) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_k[A_W-1:0];
                    w_wr_data = w_x_red;
                end
                if (r_k == '0) begin
                    n_state = ST_MUL;
                end else begin
                    n_k     = r_k - K_W'(1);
                    n_state = ST_SEED_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_RED;
            end
            ST_RED: begin
                n_x     = w_x_red;
                n_y     = w_y_red;
                n_state = ST_FIX;
            end
            ST_FIX: begin
                w_rd_en = 1'b1;
                n_slot  = w_slot;
                n_state = ST_MIX;
            end
            ST_MIX: begin
                // refill the slot and emit once the output register is free
                if (w_proceed) begin
                    w_wr_en     = 1'b1;
                    n_last      = w_mix;
                    n_out_valid = 1'b1;
                    n_out_data  = (w_mix > OUT_MAX) ? OUT_MAX : w_mix;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // a reseed starts the warm-up run from its full count
    a_reseed_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd.data.command == CMD_RESEED)
        |=> (r_state == ST_SEED_MUL && r_k == K_INIT))
        else $error("reseed did not start the warm-up run");

    // a completed mix always lands in the output register
    a_mix_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MIX && w_proceed)
        |=> (r_out_valid && r_state == ST_IDLE && r_out_data == $past(n_out_data)))
        else $error("mix result not presented");

    // presented deviates stay inside the numerator range
    a_dev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dev.valid |-> (o_dev.data.deviate != '0 && o_dev.data.deviate <= OUT_MAX))
        else $error("deviate out of range");
`endif

endmodule

@@ dv/tb_combined_lcg_shuffle_random.sv @@
// testbench for combined_lcg_shuffle_random: draw and reseed commands with random idling
// keeps its own model of both generators and the shuffle table to check every deviate
// depends on clcg_shuf_pkg, clcg_shuf_stream_if and the block's rtl
`timescale 1ns / 1ps

module tb_combined_lcg_shuffle_random;

    import clcg_shuf_pkg::*;

    localparam int     DEPTH     = TABLE_DEPTH_DEF;
    localparam longint GEN1_MUL  = longint'(MUL_ONE);
    localparam longint GEN2_MUL  = longint'(MUL_TWO);
    localparam longint GEN1_MOD  = 64'h8000_0000 - longint'(MOD_ONE_C);
    localparam longint GEN2_MOD  = 64'h8000_0000 - longint'(MOD_TWO_C);
    localparam longint TOP_VAL   = longint'(TOP_VALUE);
    localparam longint DEV_LIMIT = longint'(OUT_MAX);
    localparam longint SLOT_DIV  = 1 + TOP_VAL / DEPTH;
    localparam int     MAX_CYCLES = 500000;
    localparam int     DRAIN_CYCLES = 100;

    // generator pair with shuffle table, tracked per accepted command
    class deviate_scoreboard;
        longint   gen1;
        longint   gen2;
        longint   prev_out;
        longint   shuffle[DEPTH];
        bit [30:0] expected_devs[$];
        int       errors;
        int       n_cmds;
        int       n_reseeds;
        int       n_checked;
        int       n_saturated;

        function new();
            gen1 = longint'(X_RESET);
            gen2 = longint'(Y_RESET);
            prev_out = 0;
            foreach (shuffle[i]) shuffle[i] = 0;
            errors = 0;
            n_cmds = 0;
            n_reseeds = 0;
            n_checked = 0;
            n_saturated = 0;
        endfunction

        function int pending();
            return expected_devs.size();
        endfunction

        function int current_slot();
            longint s;
            s = prev_out / SLOT_DIV;
            if (s > DEPTH - 1) s = DEPTH - 1;
            return int'(s);
        endfunction

        // advance the model by one command and queue its deviate
        function void note_cmd(t_cmd_item c);
            longint seed;
            longint mix;
            int     k;
            int     slot;
            n_cmds++;
            if (c.command == CMD_RESEED) begin
                n_reseeds++;
                seed = longint'(c.seed_value);
                if (seed == 0) seed = 1;
                gen1 = seed;
                gen2 = seed;
                // warm-up: the last DEPTH steps fill the table, newest at entry 0
                for (k = DEPTH + 7; k >= 0; k--) begin
                    gen1 = (gen1 * GEN1_MUL) % GEN1_MOD;
                    if (k < DEPTH) shuffle[k] = gen1;
                end
            end
            gen1 = (gen1 * GEN1_MUL) % GEN1_MOD;
            gen2 = (gen2 * GEN2_MUL) % GEN2_MOD;
            slot = current_slot();
            mix = shuffle[slot] - gen2;
            shuffle[slot] = gen1;
            if (mix < 1) mix = mix + TOP_VAL;
            prev_out = mix;
            if (mix > DEV_LIMIT) mix = DEV_LIMIT;
            expected_devs.push_back(mix[30:0]);
        endfunction

        // compare a delivered deviate with the oldest prediction
        function void check_dev(t_dev_item d);
            bit [30:0] exp_dev;
            if (expected_devs.size() == 0) begin
                errors++;
                $display("%0t: deviate %0d arrived with no command outstanding",
                         $time, d.deviate);
            end else begin
                exp_dev = expected_devs.pop_front();
                n_checked++;
                if (exp_dev == OUT_MAX) n_saturated++;
                if (d.deviate !== exp_dev) begin
                    errors++;
                    $display("%0t: deviate mismatch, expected %0d, actual %0d",
                             $time, exp_dev, d.deviate);
                end
            end
        endfunction

        // search for a reseed value whose draw lands above the saturation limit;
        // table entry of the current slot and y after one step both grow linearly in the seed
        function bit [30:0] seed_for_saturation();
            longint mult;
            longint tab;
            longint yv;
            longint mix;
            longint s;
            bit     found;
            int     n;
            mult = 1;
            for (n = 0; n < DEPTH + 8 - current_slot(); n++) mult = (mult * GEN1_MUL) % GEN1_MOD;
            tab = mult;
            yv = GEN2_MUL;
            s = 1;
            found = 1'b0;
            while (!found && s < (64'd1 << 26)) begin
                mix = tab - yv;
                if (mix < 1) mix = mix + TOP_VAL;
                if (mix > DEV_LIMIT) begin
                    found = 1'b1;
                end else begin
                    s++;
                    tab = tab + mult;
                    if (tab >= GEN1_MOD) tab = tab - GEN1_MOD;
                    yv = yv + GEN2_MUL;
                    if (yv >= GEN2_MOD) yv = yv - GEN2_MOD;
                end
            end
            return found ? s[30:0] : 31'd1;
        endfunction
    endclass

    bit   clk;
    logic rst_n;
    int   cycles;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_left;
    deviate_scoreboard sb;

    clcg_shuf_stream_if #(.T(t_cmd_item)) cmd_if ();
    clcg_shuf_stream_if #(.T(t_dev_item)) dev_if ();

    combined_lcg_shuffle_random #(
        .TABLE_DEPTH (DEPTH)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_dev   (dev_if)
    );

    // clock, 4 ns period
    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("timeout after %0d cycles, %0d deviates outstanding", cycles, sb.pending());
            $display("FAILURE");
            $finish;
        end
    end

    // monitors for accepted transactions on both channels
    always @(posedge clk) begin
        if (rst_n && cmd_if.valid && cmd_if.ready) sb.note_cmd(cmd_if.data);
        if (rst_n && dev_if.valid && dev_if.ready) sb.check_dev(dev_if.data);
    end

    // receiver: random stalls, or a long hold-off when requested
    initial begin
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                dev_if.ready <= 1'b0;
            end else begin
                dev_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // offer one command, with random idle cycles first; returns on a falling edge
    task automatic send_cmd(input logic cmd, input logic [30:0] seed);
        t_cmd_item c;
        c.command = cmd;
        c.seed_value = seed;
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data <= c;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering and wait for every outstanding deviate
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    // seeds around the moduli, small and full-range values
    function automatic logic [30:0] pick_seed();
        logic [30:0] s;
        case ($urandom_range(5))
            0: s = 31'($urandom_range(16));
            1: s = 31'(GEN1_MOD - 2 + $urandom_range(4));
            2: s = 31'(GEN2_MOD - 2 + $urandom_range(4));
            3: s = 31'h7FFF_FFFF - 31'($urandom_range(8));
            default: s = 31'($urandom);
        endcase
        return s;
    endfunction

    // extremes, stuck generators and saturation
    task automatic run_directed();
        send_cmd(CMD_DRAW, 31'd0);
        send_cmd(CMD_DRAW, 31'h7FFF_FFFF);
        send_cmd(CMD_DRAW, 31'd12345);
        send_cmd(CMD_RESEED, 31'd0);
        send_cmd(CMD_DRAW, 31'd0);
        send_cmd(CMD_RESEED, 31'd1);
        send_cmd(CMD_RESEED, 31'h7FFF_FFFF);
        send_cmd(CMD_DRAW, 31'h5555_5555);
        // generator one stuck at zero
        send_cmd(CMD_RESEED, 31'(GEN1_MOD));
        send_cmd(CMD_DRAW, 31'h2AAA_AAAA);
        send_cmd(CMD_DRAW, 31'd0);
        // generator two stuck at zero
        send_cmd(CMD_RESEED, 31'(GEN2_MOD));
        send_cmd(CMD_DRAW, 31'd0);
        send_cmd(CMD_DRAW, 31'd0);
        send_cmd(CMD_RESEED, 31'(GEN1_MOD + 1));
        send_cmd(CMD_RESEED, 31'(GEN2_MOD - 1));
        send_cmd(CMD_RESEED, 31'h5555_5555);
        send_cmd(CMD_RESEED, 31'h2AAA_AAAA);
        send_cmd(CMD_DRAW, 31'd0);
        // saturated deviate
        send_cmd(CMD_RESEED, sb.seed_for_saturation());
        send_cmd(CMD_DRAW, 31'd0);
        send_cmd(CMD_RESEED, sb.seed_for_saturation());
    endtask

    task automatic run_random(input int n_items, input int hold_cycles);
        int i;
        hold_left = hold_cycles;
        for (i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < 12) send_cmd(CMD_RESEED, pick_seed());
            else send_cmd(CMD_DRAW, 31'($urandom));
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        hold_left = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.data = '0;
        dev_if.ready = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        wait_drained();

        // sender idles less than the receiver
        send_idle_pct = 18;
        recv_idle_pct = 50;
        run_random(150, 0);
        wait_drained();

        // receiver idles less than the sender
        send_idle_pct = 50;
        recv_idle_pct = 18;
        run_random(150, 0);
        wait_drained();

        // no idling, opened by a long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(150, 250);
        cmd_if.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("ran %0d commands with %0d reseeds; %0d deviates checked, %0d at the limit",
                 sb.n_cmds, sb.n_reseeds, sb.n_checked, sb.n_saturated);
        $display("%0d mismatches, %0d deviates still expected", sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
